@@ design/blg_pkg.sv @@
`default_nettype none

package blg_pkg;

    // Orientation of one line, decided by the front end
    typedef struct packed {
        logic xmajor;    // major axis is x
        logic minor_up;  // minor coordinate steps upwards
    } blg_dir_t;

    // Queue occupancy seen by both sides of the queue
    typedef struct packed {
        logic full;
        logic empty;
    } blg_qstat_t;

    // Stepper status, observed at the top level
    typedef struct packed {
        logic busy;
        logic emit;
        logic last;
    } blg_bstat_t;

endpackage

`default_nettype wire

@@ design/blg_ifs.sv @@
`default_nettype none

// Line request channel: two endpoints per transaction
interface blg_req_if #(
    parameter int N = 6
) ();
    logic         valid;
    logic         ready;
    logic [N-1:0] start_x;
    logic [N-1:0] start_y;
    logic [N-1:0] end_x;
    logic [N-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

// Point channel: one grid point per transaction
interface blg_pt_if #(
    parameter int N = 6
) ();
    logic         valid;
    logic         ready;
    logic [N-1:0] point_x;
    logic [N-1:0] point_y;
    logic         last_point;

    modport source (output valid, output point_x, output point_y,
                    output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input last_point, output ready);
endinterface

`default_nettype wire

@@ design/blg_queue.sv @@
`default_nettype none

module blg_queue
    import blg_pkg::*;
#(
    parameter int W = 26
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic      [W-1:0] pop_data,
    output blg_qstat_t        stat
);

    // Two-entry queue: head slot feeds the back end, tail slot buffers
    logic         head_vld_reg;
    logic         head_vld_next;
    logic         tail_vld_reg;
    logic         tail_vld_next;
    logic [W-1:0] head_reg;
    logic [W-1:0] head_next;
    logic [W-1:0] tail_reg;
    logic [W-1:0] tail_next;

    assign pop_data   = head_reg;
    assign stat.full  = tail_vld_reg;
    assign stat.empty = !head_vld_reg;

    // Advance slots on push and pop
    always_comb
    begin
        head_vld_next = head_vld_reg;
        tail_vld_next = tail_vld_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        if (pop)
        begin
            if (tail_vld_reg)
            begin
                head_next     = tail_reg;
                tail_vld_next = push;
                tail_next     = push_data;
            end
            else
            begin
                head_vld_next = push;
                head_next     = push_data;
            end
        end
        else if (push)
        begin
            if (head_vld_reg)
            begin
                tail_vld_next = 1'b1;
                tail_next     = push_data;
            end
            else
            begin
                head_vld_next = 1'b1;
                head_next     = push_data;
            end
        end
    end

    // Hold occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            tail_vld_reg <= tail_vld_next;
        end
    end

    // Hold entry payloads
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

@@ design/blg_front.sv @@
`default_nettype none

module blg_front
    import blg_pkg::*;
#(
    parameter int N = 6,
    parameter int W = 4 * N + 2
) (
    blg_req_if.sink            request,
    input  blg_qstat_t         qstat,
    output logic               push,
    output logic       [W-1:0] push_data
);

    typedef struct packed {
        blg_dir_t     dir;
        logic [N-1:0] mc;
        logic [N-1:0] nc;
        logic [N-1:0] major;
        logic [N-1:0] minor;
    } cmd_t;

    logic [N-1:0] adx;
    logic [N-1:0] ady;
    logic         xmajor;
    logic         swap;
    logic [N-1:0] sx;
    logic [N-1:0] sy;
    logic [N-1:0] ex;
    logic [N-1:0] ey;
    cmd_t         cmd;

    // Take a request whenever the queue has room
    assign request.ready = !qstat.full;
    assign push          = request.valid && !qstat.full;

    // Classify: absolute deltas and major axis
    always_comb
    begin
        if (request.end_x >= request.start_x)
            adx = request.end_x - request.start_x;
        else
            adx = request.start_x - request.end_x;
        if (request.end_y >= request.start_y)
            ady = request.end_y - request.start_y;
        else
            ady = request.start_y - request.end_y;
        xmajor = (adx >= ady);
    end

    // Order endpoints so the line runs up the major axis
    always_comb
    begin
        if (xmajor)
            swap = (request.start_x > request.end_x);
        else
            swap = (request.start_y > request.end_y);
        sx = swap ? request.end_x   : request.start_x;
        sy = swap ? request.end_y   : request.start_y;
        ex = swap ? request.start_x : request.end_x;
        ey = swap ? request.start_y : request.end_y;

        cmd.dir.xmajor = xmajor;
        if (xmajor)
        begin
            cmd.dir.minor_up = (ey >= sy);
            cmd.mc           = sx;
            cmd.nc           = sy;
            cmd.major        = adx;
            cmd.minor        = ady;
        end
        else
        begin
            cmd.dir.minor_up = (ex >= sx);
            cmd.mc           = sy;
            cmd.nc           = sx;
            cmd.major        = ady;
            cmd.minor        = adx;
        end
    end

    assign push_data = cmd;

endmodule

`default_nettype wire

@@ design/blg_back.sv @@
`default_nettype none

module blg_back
    import blg_pkg::*;
#(
    parameter int N = 6,
    parameter int W = 4 * N + 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  blg_qstat_t        qstat,
    input  wire logic [W-1:0] pop_data,
    output logic              pop,
    output blg_bstat_t        stat,
    blg_pt_if.source          points
);

    localparam int E = N + 3;

    typedef struct packed {
        blg_dir_t     dir;
        logic [N-1:0] mc;
        logic [N-1:0] nc;
        logic [N-1:0] major;
        logic [N-1:0] minor;
    } cmd_t;

    cmd_t                cmd;
    logic                busy_reg;
    logic                out_valid_reg;
    blg_dir_t            dir_reg;
    logic [N-1:0]        mc_reg;
    logic [N-1:0]        nc_reg;
    logic [N-1:0]        remain_reg;
    logic signed [E-1:0] err_reg;
    logic signed [E-1:0] minor2_reg;
    logic signed [E-1:0] major2_reg;
    logic [N-1:0]        px_reg;
    logic [N-1:0]        py_reg;
    logic                last_reg;
    logic signed [E-1:0] minor2;
    logic signed [E-1:0] major2;
    logic signed [E-1:0] err_next;
    logic [N-1:0]        nc_next;
    logic                free;
    logic                emit;
    logic                last;

    assign cmd    = cmd_t'(pop_data);
    assign minor2 = signed'({2'b00, cmd.minor, 1'b0});
    assign major2 = signed'({2'b00, cmd.major, 1'b0});

    // Load a new line only when the stepper is idle
    assign pop  = !busy_reg && !qstat.empty;
    assign free = !out_valid_reg || points.ready;
    assign emit = busy_reg && free;
    assign last = (remain_reg == '0);

    assign stat.busy = busy_reg;
    assign stat.emit = emit;
    assign stat.last = last;

    // Error update and minor-axis step
    always_comb
    begin
        if (!err_reg[E-1])
        begin
            err_next = err_reg + minor2_reg - major2_reg;
            nc_next  = dir_reg.minor_up ? nc_reg + 1'b1 : nc_reg - 1'b1;
        end
        else
        begin
            err_next = err_reg + minor2_reg;
            nc_next  = nc_reg;
        end
    end

    // Hold control: busy flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (emit && last)
                busy_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (points.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load or advance the stepper, register the emitted point
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dir_reg    <= cmd.dir;
            mc_reg     <= cmd.mc;
            nc_reg     <= cmd.nc;
            remain_reg <= cmd.major;
            minor2_reg <= minor2;
            major2_reg <= major2;
            err_reg    <= minor2 - signed'({3'b000, cmd.major});
        end
        else if (emit)
        begin
            mc_reg     <= mc_reg + 1'b1;
            nc_reg     <= nc_next;
            remain_reg <= remain_reg - 1'b1;
            err_reg    <= err_next;
        end
        if (emit)
        begin
            px_reg   <= dir_reg.xmajor ? mc_reg : nc_reg;
            py_reg   <= dir_reg.xmajor ? nc_reg : mc_reg;
            last_reg <= last;
        end
    end

    assign points.valid      = out_valid_reg;
    assign points.point_x    = px_reg;
    assign points.point_y    = py_reg;
    assign points.last_point = last_reg;

endmodule

`default_nettype wire

@@ design/bresenham_line_point_generator.sv @@
// A request reaches the output through the queue head slot, stepper and output register.
// A line of major+1 points holds the stepper for its load and then one point per cycle
// unless the output stalls; the stepper and output stall set the pace.
// A two-entry queue lets up to two further requests be taken while a line is drawn.
// Reset: asynchronous, active low; clears queue occupancy, stepper busy and output valid.
`default_nettype none

module bresenham_line_point_generator
    import blg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  wire logic clk,
    input  wire logic rst_n,
    blg_req_if.sink   request,
    blg_pt_if.source  points
);

    localparam int W = 4 * COORD_BITS + 2;

    blg_qstat_t   qstat;
    blg_bstat_t   bstat;
    logic         push;
    logic         pop;
    logic [W-1:0] push_data;
    logic [W-1:0] pop_data;

    // Classify requests
    blg_front #(.N(COORD_BITS), .W(W)) u_front (
        .request   (request),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple front and back
    blg_queue #(.W(W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (qstat)
    );

    // Step along the line
    blg_back #(.N(COORD_BITS), .W(W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .stat     (bstat),
        .points   (points)
    );

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.emit && bstat.last |=> !bstat.busy)
        else $error("stepper still busy after last point");

    a_emit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.emit |-> bstat.busy)
        else $error("point emitted while stepper idle");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue both full and empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |-> !qstat.full)
        else $error("request taken into a full queue");

endmodule

`default_nettype wire
